// File: hdl/mcwrl_pkg.sv
// Shared constants, state encoding and control structs for the window rate limiter.
package mcwrl_pkg;

    // Default sizing handed to the top-level parameters
    localparam int DEF_CORE_CNT   = 8;
    localparam int DEF_RING_DEPTH = 16;
    localparam int DEF_SLOT_US    = 100;

    // Fixed field widths
    localparam int NOW_W      = 32;
    localparam int CORE_FLD_W = 3;
    localparam int LEN_W      = 16;
    localparam int ACT_W      = 4;
    localparam int CNT_W      = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register reset values
    localparam logic [ACT_W-1:0] RST_ACTIVE_CORES = 4'd8;
    localparam logic [CNT_W-1:0] RST_LIMIT_BYTES  = 32'd2684355;

    // Register select, taken from paddr bit 2
    localparam logic REG_ACTIVE_CORES = 1'b0;
    localparam logic REG_LIMIT_BYTES  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_SEND,
        S_WAIT,
        S_DECIDE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic start;      // latch the accepted request
        logic issue;      // push one core into the slot pipeline
        logic issue_snd;  // the pushed entry is the sender lookup
        logic commit;     // decide, count and load the result
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic bad_sender; // request names a core that does not exist
        logic snd_done;   // sender lookup has reached the last stage
    } t_stat;

endpackage

// File: hdl/mcwrl_ctrl.sv
// Controller state machine: sequences the core walk, the sender lookup and the decision.
module mcwrl_ctrl
    import mcwrl_pkg::*;
#(
    parameter int CORE_CNT = DEF_CORE_CNT,
    localparam int CORE_W = (CORE_CNT > 1) ? $clog2(CORE_CNT) : 1,
    localparam int WALK_W = $clog2(CORE_CNT + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [ACT_W-1:0]  i_active_cores,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_cmd              o_cmd,
    output logic [CORE_W-1:0] o_core,
    input  t_stat             i_stat
);

    t_state              r_state, n_state;
    logic [CORE_W-1:0]   r_core, n_core;
    logic [WALK_W-1:0]   r_walk, n_walk;
    logic                r_out_vld, n_out_vld;
    logic [WALK_W-1:0]   w_walk_in;
    logic                w_accept;
    logic                w_last;
    logic                w_out_free;
    logic                w_out_take;

    // Clamp the active core count to the cores that exist
    always_comb begin
        if ({3'b000, i_active_cores} > 7'(CORE_CNT)) begin
            w_walk_in = WALK_W'(CORE_CNT);
        end else begin
            w_walk_in = WALK_W'(i_active_cores);
        end
    end

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_last     = (WALK_W'(r_core) + WALK_W'(1)) == r_walk;
    assign w_out_take = r_out_vld && !i_out_stall;
    assign w_out_free = !r_out_vld || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        n_core  = r_core;
        n_walk  = r_walk;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_walk = w_walk_in;
                    n_core = '0;
                    if (i_stat.bad_sender) begin
                        n_state = S_DECIDE;
                    end else if (w_walk_in == '0) begin
                        n_state = S_SEND;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (w_last) begin
                    n_state = S_SEND;
                end else begin
                    n_core = r_core + CORE_W'(1);
                end
            end
            S_SEND: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_stat.snd_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.start = i_in_valid;
            end
            S_WALK: begin
                o_cmd.issue = 1'b1;
            end
            S_SEND: begin
                o_cmd.issue     = 1'b1;
                o_cmd.issue_snd = 1'b1;
            end
            S_WAIT: begin
                o_cmd = '0;
            end
            S_DECIDE: begin
                o_cmd.commit = w_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_core = r_core;

    // Hold the result until the consumer takes it
    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.commit) begin
            n_out_vld = 1'b1;
        end else if (w_out_take) begin
            n_out_vld = 1'b0;
        end
    end

    assign o_out_valid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_core    <= '0;
            r_walk    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_core    <= n_core;
            r_walk    <= n_walk;
            r_out_vld <= n_out_vld;
        end
    end

    // The sender lookup only completes while the controller waits for it
    a_snd_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.snd_done |-> (r_state == S_WAIT))
        else $error("sender lookup finished outside the wait state");

    // The walk never issues a core beyond the active count
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (WALK_W'(r_core) < r_walk))
        else $error("walk issued a core past the active count");

    // A request for a missing core skips the walk entirely
    a_bad_skips_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.start && i_stat.bad_sender) |=> (r_state == S_DECIDE))
        else $error("request for a missing core entered the walk");

endmodule

// File: hdl/mcwrl_dpath.sv
// Datapath: window starts, slot count memory, slot index pipeline and byte total.
module mcwrl_dpath
    import mcwrl_pkg::*;
#(
    parameter int CORE_CNT   = DEF_CORE_CNT,
    parameter int RING_DEPTH = DEF_RING_DEPTH,
    parameter int SLOT_US    = DEF_SLOT_US,
    localparam int CORE_W = (CORE_CNT > 1) ? $clog2(CORE_CNT) : 1,
    localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
    localparam int DEPTH  = CORE_CNT * RING_DEPTH,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int TOT_W  = CNT_W + $clog2(CORE_CNT + 1) + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [CORE_W-1:0]     i_core,
    output t_stat                 o_stat,
    input  logic [NOW_W-1:0]      i_now_us,
    input  logic [CORE_FLD_W-1:0] i_sending_core,
    input  logic [LEN_W-1:0]      i_packet_length,
    input  logic [CNT_W-1:0]      i_limit_bytes,
    output logic                  o_allowed
);

    // Reciprocal of the slot length: floor(2^32 / SLOT_US), at most one short
    localparam logic [32:0] RECIP    = 33'((64'd1 << 32) / 64'(SLOT_US));
    localparam logic [32:0] SPAN     = 33'(64'(RING_DEPTH) * 64'(SLOT_US));
    localparam logic [31:0] SLOT_LEN = 32'(SLOT_US);

    // Request registers
    logic [NOW_W-1:0]  r_now;
    logic [LEN_W-1:0]  r_plen;
    logic [CORE_W-1:0] r_sender;
    logic              r_bad;
    logic [TOT_W-1:0]  r_total;
    logic              r_allowed;

    // Per-core state and slot counts
    logic [NOW_W-1:0]  r_wstart [CORE_CNT];
    logic [CNT_W-1:0]  mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;

    // Slot pipeline
    logic              r_a_v, r_a_snd;
    logic [CORE_W-1:0] r_a_core;
    logic [NOW_W-1:0]  r_a_e;
    logic              r_b_v, r_b_snd;
    logic [CORE_W-1:0] r_b_core;
    logic [NOW_W-1:0]  r_b_e;
    logic [64:0]       r_b_prod;
    logic              r_c_v, r_c_snd, r_c_past;
    logic [CORE_W-1:0] r_c_core;
    logic [SLOT_W-1:0] r_c_q0;
    logic [31:0]       r_c_rem;
    logic              r_d_v, r_d_snd, r_d_past, r_d_ent;
    logic [ADDR_W-1:0] r_d_addr;
    logic [CNT_W-1:0]  r_rd_data;

    // Sender entry held for the decision
    logic [CNT_W-1:0]  r_snd_cnt;
    logic [ADDR_W-1:0] r_snd_addr;

    logic [CORE_W-1:0] w_a_idx;
    logic [NOW_W-1:0]  w_a_e;
    logic [64:0]       w_b_prod;
    logic [SLOT_W-1:0] w_q0;
    logic              w_past;
    logic [31:0]       w_rem;
    logic [SLOT_W-1:0] w_q;
    logic [ADDR_W-1:0] w_addr;
    logic              w_clear;
    logic              w_allow;
    logic [CNT_W:0]    w_sum;
    logic [CNT_W-1:0]  w_sat;

    assign o_stat.bad_sender = ({4'b0000, i_sending_core} >= 7'(CORE_CNT));
    assign o_stat.snd_done   = r_d_v && r_d_snd;

    // Stage A: elapsed time of the issued core
    assign w_a_idx = i_cmd.issue_snd ? r_sender : i_core;
    assign w_a_e   = r_now - r_wstart[w_a_idx];

    // Stage B: multiply by the reciprocal
    assign w_b_prod = 65'(r_a_e) * 65'(RECIP);

    // Stage C: estimated slot and its remainder, past-ring check
    assign w_q0   = SLOT_W'(r_b_prod[64:32]);
    assign w_past = {1'b0, r_b_e} >= SPAN;
    assign w_rem  = r_b_e - 32'(w_q0) * SLOT_LEN;

    // Stage D: correct the slot and form the memory address
    always_comb begin
        if (r_c_past) begin
            w_q = '0;
        end else if (r_c_rem >= SLOT_LEN) begin
            w_q = r_c_q0 + SLOT_W'(1);
        end else begin
            w_q = r_c_q0;
        end
    end

    assign w_addr  = ADDR_W'(r_c_core) * ADDR_W'(RING_DEPTH) + ADDR_W'(w_q);
    assign w_clear = r_c_v && r_c_past && !r_c_snd;

    // Decision and saturating count update
    assign w_allow = !r_bad && (r_total < TOT_W'(i_limit_bytes));
    assign w_sum   = {1'b0, r_snd_cnt} + (CNT_W + 1)'(r_plen);
    assign w_sat   = w_sum[CNT_W] ? {CNT_W{1'b1}} : w_sum[CNT_W-1:0];

    // Latch the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_now    <= i_now_us;
            r_plen   <= i_packet_length;
            r_sender <= CORE_W'(i_sending_core);
        end
    end

    // Pipeline valids and request flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v     <= 1'b0;
            r_b_v     <= 1'b0;
            r_c_v     <= 1'b0;
            r_d_v     <= 1'b0;
            r_bad     <= 1'b0;
            r_allowed <= 1'b0;
        end else begin
            r_a_v <= i_cmd.issue;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            if (i_cmd.start) begin
                r_bad <= o_stat.bad_sender;
            end
            if (i_cmd.commit) begin
                r_allowed <= w_allow;
            end
        end
    end

    // Advance the pipeline payload
    always_ff @(posedge i_clk) begin
        r_a_snd  <= i_cmd.issue_snd;
        r_a_core <= w_a_idx;
        r_a_e    <= w_a_e;
        r_b_snd  <= r_a_snd;
        r_b_core <= r_a_core;
        r_b_e    <= r_a_e;
        r_b_prod <= w_b_prod;
        r_c_snd  <= r_b_snd;
        r_c_core <= r_b_core;
        r_c_past <= w_past;
        r_c_q0   <= w_q0;
        r_c_rem  <= w_rem;
        r_d_snd  <= r_c_snd;
        r_d_past <= r_c_past;
        r_d_addr <= w_addr;
        r_d_ent  <= r_vld[w_addr];
    end

    // Slot count memory: registered read, written on a counted send
    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[w_addr];
        if (i_cmd.commit && w_allow) begin
            mem[r_snd_addr] <= w_sat;
        end
    end

    // Entry valid bits: drop a whole ring on restart, mark a written entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_clear) begin
                for (int k = 0; k < DEPTH; k++) begin
                    if (CORE_W'(k / RING_DEPTH) == r_c_core) begin
                        r_vld[k] <= 1'b0;
                    end
                end
            end
            if (i_cmd.commit && w_allow) begin
                r_vld[r_snd_addr] <= 1'b1;
            end
        end
    end

    // Window start: restart at the request time when the ring has run out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CORE_CNT; k++) begin
                r_wstart[k] <= '0;
            end
        end else if (w_clear) begin
            r_wstart[r_c_core] <= r_now;
        end
    end

    // Stage E: sum the current slots, hold the sender entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_total <= TOT_W'(i_packet_length);
        end else if (r_d_v && !r_d_snd && !r_d_past && r_d_ent) begin
            r_total <= r_total + TOT_W'(r_rd_data);
        end
        if (r_d_v && r_d_snd) begin
            r_snd_cnt  <= r_d_ent ? r_rd_data : '0;
            r_snd_addr <= r_d_addr;
        end
    end

    assign o_allowed = r_allowed;

    // The sender lookup is the last entry in flight
    a_snd_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_v && r_d_snd) |-> !(r_a_v || r_b_v || r_c_v))
        else $error("slot pipeline busy behind the sender lookup");

    // The decision only happens on a drained pipeline
    a_commit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !(r_a_v || r_b_v || r_c_v || r_d_v))
        else $error("decision taken with the slot pipeline busy");

endmodule

// File: hdl/multi_core_window_rate_limiter.sv
// Top level: configuration registers, controller and datapath of the window rate limiter.
//
// Fixed-window byte rate limiter shared by several cores. Each request
// (time, sending core, packet length) walks the active cores one per
// cycle through a five-stage slot-index pipeline: a core whose window has
// run past its ring of RING_DEPTH slots of SLOT_US microseconds restarts
// its window at the request time with an empty ring, otherwise its current
// slot count joins the total. A send whose total reaches limit_bytes is
// refused; an accepted send adds its length to the sender's slot, saturating
// at 2^32-1. The walk covers active_cores clamped to CORE_CNT and, with the
// slot pipeline behind it, sets how long a request takes from acceptance to
// its result; the final decision waits while a previous result is still
// held. A request naming a core at or above CORE_CNT is refused without a
// walk. The result sits in an output register, so the next request is
// accepted while it waits. Registers: active_cores at address 0, limit_bytes
// at address 4; write them only while the block is idle.
module multi_core_window_rate_limiter
    import mcwrl_pkg::*;
#(
    parameter int CORE_CNT   = DEF_CORE_CNT,
    parameter int RING_DEPTH = DEF_RING_DEPTH,
    parameter int SLOT_US    = DEF_SLOT_US
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [NOW_W-1:0]      i_now_us,
    input  logic [CORE_FLD_W-1:0] i_sending_core,
    input  logic [LEN_W-1:0]      i_packet_length,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_allowed,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CORE_W = (CORE_CNT > 1) ? $clog2(CORE_CNT) : 1;

    logic [ACT_W-1:0]  r_active_cores;
    logic [CNT_W-1:0]  r_limit_bytes;
    logic              w_cfg_wr;
    t_cmd              w_cmd;
    t_stat             w_stat;
    logic [CORE_W-1:0] w_core;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_cores <= RST_ACTIVE_CORES;
            r_limit_bytes  <= RST_LIMIT_BYTES;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_ACTIVE_CORES: r_active_cores <= pwdata[ACT_W-1:0];
                REG_LIMIT_BYTES:  r_limit_bytes  <= pwdata;
                default:          r_limit_bytes  <= r_limit_bytes;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (paddr[2])
            REG_ACTIVE_CORES: prdata = {{(CFG_DATA_W - ACT_W){1'b0}}, r_active_cores};
            REG_LIMIT_BYTES:  prdata = r_limit_bytes;
            default:          prdata = '0;
        endcase
    end

    mcwrl_ctrl #(
        .CORE_CNT (CORE_CNT)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_active_cores (r_active_cores),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_cmd          (w_cmd),
        .o_core         (w_core),
        .i_stat         (w_stat)
    );

    mcwrl_dpath #(
        .CORE_CNT   (CORE_CNT),
        .RING_DEPTH (RING_DEPTH),
        .SLOT_US    (SLOT_US)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_core          (w_core),
        .o_stat          (w_stat),
        .i_now_us        (i_now_us),
        .i_sending_core  (i_sending_core),
        .i_packet_length (i_packet_length),
        .i_limit_bytes   (r_limit_bytes),
        .o_allowed       (o_allowed)
    );

endmodule

// File: bench/multi_core_window_rate_limiter_tb.sv
// Self-checking testbench for the multi-core window rate limiter.
module multi_core_window_rate_limiter_tb;
    import mcwrl_pkg::*;

    localparam int unsigned CORE_CNT     = DEF_CORE_CNT;
    localparam int unsigned RING_DEPTH   = DEF_RING_DEPTH;
    localparam int unsigned SLOT_LEN     = DEF_SLOT_US;
    localparam int          DRAIN_CYCLES = 2 * (DEF_CORE_CNT + 7);
    localparam int          LIMIT_CYCLES = 200_000;
    localparam int          RAND_PHASES  = 8;
    localparam int          PHASE_ITEMS  = 70;
    localparam int          FILL_ITEMS   = 16;

    typedef enum logic { ROW_SEND, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [31:0] value;     // time stamp of a request, or register value
        logic [2:0]  core;
        logic [15:0] len;
        logic        reg_sel;
        bit          typed;     // expected result given in the row
        bit          exp_allowed;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [NOW_W-1:0]      i_now_us;
    logic [CORE_FLD_W-1:0] i_sending_core;
    logic [LEN_W-1:0]      i_packet_length;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_allowed;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow state of the limiter
    logic [31:0] win_start_m [CORE_CNT];
    logic [31:0] slot_cnt_m  [CORE_CNT][RING_DEPTH];
    logic [3:0]  act_cores_m;
    logic [31:0] limit_m;

    bit          allowed_q [$];
    int          mismatch_cnt;
    int          cycle_cnt;
    int          idle_odds;     // one cycle in idle_odds starts a burst, 0 for none
    t_stim_row   dir_rows [$];

    multi_core_window_rate_limiter u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_now_us        (i_now_us),
        .i_sending_core  (i_sending_core),
        .i_packet_length (i_packet_length),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_allowed       (o_allowed),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Generate the clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Decide one request and update the shadow windows and slot counts
    function automatic bit rate_decide(input logic [31:0] now, input logic [2:0] core,
                                       input logic [15:0] len);
        logic [31:0] elapsed;
        logic [31:0] snd_slot;
        logic [31:0] slot;
        logic [39:0] total;
        logic [32:0] sum;
        int unsigned walk;
        int          c;
        int          j;
        // a missing core is refused with no state change
        if (core >= CORE_CNT) return 1'b0;
        elapsed  = now - win_start_m[core];
        snd_slot = elapsed / SLOT_LEN;
        walk     = (act_cores_m > CORE_CNT) ? CORE_CNT : act_cores_m;
        total    = {24'd0, len};
        for (c = 0; c < walk; c++) begin
            elapsed = now - win_start_m[c];
            slot    = elapsed / SLOT_LEN;
            if (slot >= RING_DEPTH) begin
                // restart the window with an empty ring
                for (j = 0; j < RING_DEPTH; j++) slot_cnt_m[c][j] = '0;
                win_start_m[c] = now;
            end else begin
                total = total + {8'd0, slot_cnt_m[c][slot]};
            end
        end
        if (total >= {8'd0, limit_m}) return 1'b0;
        if (snd_slot >= RING_DEPTH) snd_slot = '0;
        sum = {1'b0, slot_cnt_m[core][snd_slot]} + {17'd0, len};
        slot_cnt_m[core][snd_slot] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        return 1'b1;
    endfunction

    task automatic note_mismatch(input string what, input longint expd, input longint actd);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("MISMATCH %s: expected %0d, got %0d (cycle %0d)", what, expd, actd,
                     cycle_cnt);
    endtask

    // Drive one request, hold it while stalled, and record its expected result
    task automatic send_request(input logic [31:0] now, input logic [2:0] core,
                                input logic [15:0] len, input bit typed, input bit exp);
        bit pred;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_now_us        <= now;
        i_sending_core  <= core;
        i_packet_length <= len;
        do @(posedge i_clk); while (o_in_stall);
        pred = rate_decide(now, core, len);
        allowed_q.push_back(typed ? exp : pred);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every result is back and the block has settled
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (allowed_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write one register while idle, then read it back
    task automatic set_register(input logic sel, input logic [31:0] value);
        logic [31:0] rd;
        logic [31:0] want;
        drain_block();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (sel == REG_ACTIVE_CORES) act_cores_m = value[ACT_W-1:0];
        else limit_m = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        want = (sel == REG_ACTIVE_CORES) ? {28'd0, value[ACT_W-1:0]} : value;
        if (rd !== want) note_mismatch("register read", want, rd);
    endtask

    // Stall the result channel in random bursts
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Check each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        bit exp;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (allowed_q.size() == 0) begin
                note_mismatch("result with no request pending", -1, o_allowed);
            end else begin
                exp = allowed_q.pop_front();
                if (o_allowed !== exp) note_mismatch("allowed", exp, o_allowed);
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [31:0] cur_now;
        logic [31:0] lim;
        logic [31:0] fill_now;
        logic [15:0] len;
        int          pick;
        int          p;
        int          k;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_now_us        = '0;
        i_sending_core  = '0;
        i_packet_length = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        mismatch_cnt    = 0;
        cycle_cnt       = 0;
        idle_odds       = 4;
        act_cores_m     = RST_ACTIVE_CORES;
        limit_m         = RST_LIMIT_BYTES;
        for (k = 0; k < CORE_CNT; k++) begin
            win_start_m[k] = '0;
            for (p = 0; p < RING_DEPTH; p++) slot_cnt_m[k][p] = '0;
        end

        dir_rows = '{
            // fresh state: empty rings at time zero
            '{ROW_SEND, 32'd0,          3'd0, 16'd0,     1'b0, 1'b1, 1'b1},
            '{ROW_SEND, 32'd0,          3'd7, 16'd65535, 1'b0, 1'b1, 1'b1},
            '{ROW_SEND, 32'd99,         3'd0, 16'd65535, 1'b0, 1'b0, 1'b0},
            '{ROW_SEND, 32'd100,        3'd0, 16'd1,     1'b0, 1'b0, 1'b0},
            // last slot of the ring, then one past it
            '{ROW_SEND, 32'd1599,       3'd5, 16'd1234,  1'b0, 1'b0, 1'b0},
            '{ROW_SEND, 32'd1600,       3'd5, 16'd77,    1'b0, 1'b0, 1'b0},
            // time wrap past 2^32
            '{ROW_SEND, 32'hFFFF_FFFF,  3'd1, 16'd5,     1'b0, 1'b0, 1'b0},
            '{ROW_SEND, 32'h0000_0063,  3'd1, 16'd5,     1'b0, 1'b0, 1'b0},
            // zero limit refuses everything
            '{ROW_CFG,  32'd0,          3'd0, 16'd0,     REG_LIMIT_BYTES, 1'b0, 1'b0},
            '{ROW_SEND, 32'd200,        3'd3, 16'd0,     1'b0, 1'b1, 1'b0},
            '{ROW_SEND, 32'd200,        3'd6, 16'd65535, 1'b0, 1'b1, 1'b0},
            // no core walked: total is the packet length alone
            '{ROW_CFG,  32'd0,          3'd0, 16'd0,     REG_ACTIVE_CORES, 1'b0, 1'b0},
            '{ROW_CFG,  32'd1000,       3'd0, 16'd0,     REG_LIMIT_BYTES, 1'b0, 1'b0},
            '{ROW_SEND, 32'd5000,       3'd4, 16'd999,   1'b0, 1'b1, 1'b1},
            '{ROW_SEND, 32'd5000,       3'd4, 16'd1000,  1'b0, 1'b1, 1'b0},
            // sender not walked and past its ring: count into slot 0
            '{ROW_SEND, 32'd90000,      3'd4, 16'd10,    1'b0, 1'b0, 1'b0},
            '{ROW_CFG,  32'd1,          3'd0, 16'd0,     REG_ACTIVE_CORES, 1'b0, 1'b0},
            '{ROW_SEND, 32'd90000,      3'd2, 16'd500,   1'b0, 1'b0, 1'b0},
            // active cores above the core count
            '{ROW_CFG,  32'd15,         3'd0, 16'd0,     REG_ACTIVE_CORES, 1'b0, 1'b0},
            '{ROW_CFG,  32'hFFFF_FFFF,  3'd0, 16'd0,     REG_LIMIT_BYTES, 1'b0, 1'b0},
            '{ROW_SEND, 32'd90050,      3'd7, 16'd65535, 1'b0, 1'b0, 1'b0},
            '{ROW_SEND, 32'hFFFF_FFFF,  3'd0, 16'd65535, 1'b0, 1'b0, 1'b0},
            '{ROW_CFG,  32'd8,          3'd0, 16'd0,     REG_ACTIVE_CORES, 1'b0, 1'b0},
            '{ROW_CFG,  32'd2684355,    3'd0, 16'd0,     REG_LIMIT_BYTES, 1'b0, 1'b0},
            '{ROW_SEND, 32'd200000,     3'd0, 16'd65535, 1'b0, 1'b0, 1'b0},
            '{ROW_SEND, 32'd200001,     3'd6, 16'h5555,  1'b0, 1'b0, 1'b0},
            '{ROW_SEND, 32'd200002,     3'd3, 16'hAAAA,  1'b0, 1'b0, 1'b0}
        };

        // Hold reset, then release it
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG)
                set_register(dir_rows[i].reg_sel, dir_rows[i].value);
            else
                send_request(dir_rows[i].value, dir_rows[i].core, dir_rows[i].len,
                             dir_rows[i].typed, dir_rows[i].exp_allowed);
        end

        // Random phases, each under its own setting
        cur_now = 32'd300000;
        for (p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: pick = 2;
                1: pick = 3;
                2: pick = 1;
                3: pick = 2;
                4: pick = 5;
                5: pick = 4;
                default: pick = $urandom_range(0, 5);
            endcase
            case (pick)
                0: lim = 32'd0;
                1: lim = $urandom_range(1, 5000);
                2: lim = $urandom_range(50000, 400000);
                3: lim = RST_LIMIT_BYTES;
                4: lim = $urandom;
                default: lim = 32'hFFFF_FFFF;
            endcase
            set_register(REG_ACTIVE_CORES,
                         (p == 0) ? 32'd1 : (p == 1) ? 32'd8 : (p == 2) ? 32'd15
                                          : $urandom_range(0, 15));
            set_register(REG_LIMIT_BYTES, lim);
            idle_odds = (p == 3) ? 0 : (2 << $urandom_range(0, 2));
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // advance time: mostly within the ring, now and then past it or wrapped
                pick = $urandom_range(0, 99);
                if (pick < 70)      cur_now = cur_now + $urandom_range(0, 60);
                else if (pick < 85) cur_now = cur_now + $urandom_range(100, 400);
                else if (pick < 93) cur_now = cur_now + $urandom_range(1600, 5000);
                else if (pick < 97) cur_now = $urandom;
                else                cur_now = cur_now - $urandom_range(1, 200);
                pick = $urandom_range(0, 99);
                if (pick < 40)      len = 16'($urandom_range(0, 2000));
                else if (pick < 80) len = 16'($urandom_range(0, 65535));
                else if (pick < 90) len = 16'hFFFF;
                else if (pick < 95) len = 16'd0;
                else                len = 16'd1 << $urandom_range(0, 15);
                send_request(cur_now, 3'($urandom_range(0, 7)), len, 1'b0, 1'b0);
            end
        end

        // Last part, no idling: pile full packets onto one slot, then walk all cores
        idle_odds = 0;
        set_register(REG_ACTIVE_CORES, 32'd0);
        set_register(REG_LIMIT_BYTES, 32'hFFFF_FFFF);
        fill_now = win_start_m[2] + 32'd3;
        for (k = 0; k < FILL_ITEMS; k++)
            send_request(fill_now, 3'd2, 16'hFFFF, 1'b0, 1'b0);
        set_register(REG_ACTIVE_CORES, 32'd8);
        send_request(fill_now, 3'd2, 16'd0, 1'b0, 1'b0);
        send_request(fill_now, 3'd5, 16'd1, 1'b0, 1'b0);
        send_request(fill_now + 32'd40, 3'd2, 16'hFFFF, 1'b0, 1'b0);

        drain_block();
        if (mismatch_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
